// File: src/rti_pkg.sv
`timescale 1ns / 1ps

package rti_pkg;

    // coordinate width, clamped to the 32-bit field width
    localparam int COORD_WIDTH = 32;
    localparam int CW   = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int FRAC = 16;
    localparam int DIFW = CW + 1;            // vertex differences
    localparam int PRW  = 2 * DIFW;          // cross product partials
    localparam int CRW  = PRW + 1;           // cross products
    localparam int LOW  = (CRW + 1) / 2;     // low split of a cross product
    localparam int HIW  = CRW - LOW;
    localparam int LPW  = DIFW + LOW + 1;    // low partial of a dot term
    localparam int HPW  = DIFW + HIW;        // high partial of a dot term
    localparam int DOTW = DIFW + CRW + 2;    // dot products
    localparam int SUMW = DOTW + 1;
    localparam int NUMW = DOTW + FRAC;       // dividend magnitude
    localparam int EPS_LOG = 28;             // accepted determinant is at least 2^28
    localparam int QW   = NUMW - EPS_LOG;    // quotient magnitude bits
    localparam int QSW  = QW + 1;
    localparam int SATW = QSW + 2;
    localparam int RW   = DOTW + 1;

    localparam logic signed [DOTW-1:0] DET_EPS = DOTW'(281474976);
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [31:0] T_MISS  = 32'sh7FFF_FFFF;

    // cross product operand order
    localparam int XA [3] = '{1, 2, 0};
    localparam int XB [3] = '{2, 0, 1};

    typedef enum logic [2:0] {
        REG_ORG_X = 3'd0,
        REG_ORG_Y = 3'd1,
        REG_ORG_Z = 3'd2,
        REG_DIR_X = 3'd3,
        REG_DIR_Y = 3'd4,
        REG_DIR_Z = 3'd5,
        REG_WIN_MIN = 3'd6,
        REG_WIN_MAX = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] vert0_x;
        logic signed [31:0] vert0_y;
        logic signed [31:0] vert0_z;
        logic signed [31:0] vert1_x;
        logic signed [31:0] vert1_y;
        logic signed [31:0] vert1_z;
        logic signed [31:0] vert2_x;
        logic signed [31:0] vert2_y;
        logic signed [31:0] vert2_z;
        logic               group_last;
    } t_tri_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_distance;
        logic signed [31:0] bary_u;
        logic signed [31:0] bary_v;
        logic signed [31:0] bary_w;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic               group_last_out;
    } t_hit_out;

    typedef struct packed {
        logic signed [31:0] org_x;
        logic signed [31:0] org_y;
        logic signed [31:0] org_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray_cfg;

    // flags and normal that ride alongside the dividers
    typedef struct packed {
        logic               group_last;
        logic               cull_ok;
        logic               bary_ok;
        logic [2:0]         neg;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
    } t_div_side;

    function automatic logic signed [DIFW-1:0] coord(input logic [31:0] x);
        return DIFW'(signed'(x[CW-1:0]));
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] x);
        logic ovf;
        ovf = !((&x[SATW-1:31]) || !(|x[SATW-1:31]));
        if (!ovf) begin
            return x[31:0];
        end
        return x[SATW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

endpackage

// File: src/ray_triangle_intersect.sv
`timescale 1ns / 1ps
// pipeline: 7 setup stages, one divider stage per quotient bit, 2 finish
// stages, 1 output register
// throughput: one triangle per cycle unless the skid is full; a 2-entry
// output stage (register plus skid) takes requests while one result waits
// reset: synchronous active low; clears all valid bits and sets the ray
// registers to zero and the distance window to [0, max]
module ray_triangle_intersect import rti_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // triangle requests
    input  logic        i_tri_valid,
    output logic        o_tri_ready,
    input  t_tri_in     i_tri,
    // results
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_hit_out    o_res,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // ray and window registers
    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic signed [31:0] r_dir_x, r_dir_y, r_dir_z;
    logic signed [31:0] r_win_min, r_win_max;

    // pipeline enable: the whole pipe moves unless the skid entry is full
    logic       ce;
    t_ray_cfg   ray;

    logic            su_valid;
    t_div_side       su_side;
    logic [DOTW-1:0] su_den;
    logic [NUMW-1:0] su_num [3];

    logic            dv_valid;
    t_div_side       dv_side;
    logic [QW-1:0]   dv_quo [3];

    logic            fin_valid;
    t_hit_out        fin_res;

    // output register and skid entry
    logic       r_out_vld, r_skid_vld;
    t_hit_out   r_out, r_skid;
    logic       take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_org_z   <= '0;
            r_dir_x   <= '0;
            r_dir_y   <= '0;
            r_dir_z   <= '0;
            r_win_min <= '0;
            r_win_max <= 32'sh7FFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ORG_X:   r_org_x   <= i_cfg_data;
                REG_ORG_Y:   r_org_y   <= i_cfg_data;
                REG_ORG_Z:   r_org_z   <= i_cfg_data;
                REG_DIR_X:   r_dir_x   <= i_cfg_data;
                REG_DIR_Y:   r_dir_y   <= i_cfg_data;
                REG_DIR_Z:   r_dir_z   <= i_cfg_data;
                REG_WIN_MIN: r_win_min <= i_cfg_data;
                REG_WIN_MAX: r_win_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ray = '{org_x: r_org_x, org_y: r_org_y, org_z: r_org_z,
                   dir_x: r_dir_x, dir_y: r_dir_y, dir_z: r_dir_z};

    assign ce          = !r_skid_vld;
    assign o_tri_ready = ce;

    // edges, cross products, dot products, range flags
    rti_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_tri_valid),
        .i_tri   (i_tri),
        .i_ray   (ray),
        .o_valid (su_valid),
        .o_side  (su_side),
        .o_den   (su_den),
        .o_num   (su_num)
    );

    // u, v and t quotients, one bit per stage
    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (su_valid),
        .i_side  (su_side),
        .i_den   (su_den),
        .i_num   (su_num),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_quo   (dv_quo)
    );

    // sign, window test, saturation and culled-case values
    rti_fin u_fin (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (ce),
        .i_valid   (dv_valid),
        .i_side    (dv_side),
        .i_quo     (dv_quo),
        .i_win_min (r_win_min),
        .i_win_max (r_win_max),
        .o_valid   (fin_valid),
        .o_res     (fin_res)
    );

    assign take = r_out_vld && i_res_ready;

    // while the skid holds a result the pipe is frozen and the skid drains
    // first; otherwise the pipe's last stage goes to the output register
    // when it frees up, or parks in the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || take) begin
            r_out_vld <= fin_valid;
        end else if (fin_valid) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || take) begin
            r_out <= fin_res;
        end else begin
            r_skid <= fin_res;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule

// File: src/rti_setup.sv
`timescale 1ns / 1ps

module rti_setup import rti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  t_tri_in           i_tri,
    input  t_ray_cfg          i_ray,
    output logic              o_valid,
    output t_div_side         o_side,
    output logic [DOTW-1:0]   o_den,
    output logic [NUMW-1:0]   o_num [3]
);

    localparam int NS = 7;

    logic [NS-1:0] r_vld;
    logic          r_last [NS-1];

    // stage 1: differences
    logic signed [DIFW-1:0] r1_e0 [3], r1_e2 [3], r1_tv [3], r1_d [3];
    // stage 2: cross partials
    logic signed [PRW-1:0]  r2_pa [3][3], r2_pb [3][3];
    logic signed [DIFW-1:0] r2_e0 [3], r2_e2 [3], r2_tv [3], r2_d [3];
    // stage 3: crosses (0 normal, 1 p, 2 q)
    logic signed [CRW-1:0]  r3_x [3][3];
    logic signed [DIFW-1:0] r3_e0 [3], r3_e2 [3], r3_tv [3], r3_d [3];
    // stage 4: dot partials (0 det, 1 nu, 2 nv, 3 nt)
    logic signed [LPW-1:0]  r4_lo [4][3];
    logic signed [HPW-1:0]  r4_hi [4][3];
    logic signed [CRW-1:0]  r4_n [3];
    // stage 5: dot terms
    logic signed [DOTW-1:0] r5_t [4][3];
    logic signed [CRW-1:0]  r5_n [3];
    // stage 6: dot sums
    logic signed [DOTW-1:0] r6_s [4];
    logic signed [CRW-1:0]  r6_n [3];
    // stage 7
    t_div_side              r7_side;
    logic [DOTW-1:0]        r7_den;
    logic [NUMW-1:0]        r7_num [3];

    logic [31:0]            in_v [9];
    logic [31:0]            ray_o [3], ray_d [3];
    logic signed [DIFW-1:0] n1_e0 [3], n1_e2 [3], n1_tv [3], n1_d [3];
    logic signed [PRW-1:0]  n2_pa [3][3], n2_pb [3][3];
    logic signed [DIFW-1:0] da [4][3];
    logic signed [CRW-1:0]  db [4][3];
    logic signed [LPW-1:0]  n4_lo [4][3];
    logic signed [HPW-1:0]  n4_hi [4][3];
    logic signed [DOTW-1:0] n5_t [4][3];
    logic signed [DOTW-1:0] n6_s [4];
    logic signed [DOTW-1:0] det, nu, nv, nt;
    logic signed [DOTW-1:0] nums [3];
    logic [DOTW-1:0]        mag;
    t_div_side              n7_side;
    logic [NUMW-1:0]        n7_num [3];
    logic signed [31:0]     nsat [3];

    always_comb begin
        in_v[0] = i_tri.vert0_x; in_v[1] = i_tri.vert0_y; in_v[2] = i_tri.vert0_z;
        in_v[3] = i_tri.vert1_x; in_v[4] = i_tri.vert1_y; in_v[5] = i_tri.vert1_z;
        in_v[6] = i_tri.vert2_x; in_v[7] = i_tri.vert2_y; in_v[8] = i_tri.vert2_z;
        ray_o[0] = i_ray.org_x; ray_o[1] = i_ray.org_y; ray_o[2] = i_ray.org_z;
        ray_d[0] = i_ray.dir_x; ray_d[1] = i_ray.dir_y; ray_d[2] = i_ray.dir_z;
        for (int i = 0; i < 3; i++) begin
            n1_e0[i] = coord(in_v[3+i]) - coord(in_v[i]);
            n1_e2[i] = coord(in_v[6+i]) - coord(in_v[i]);
            n1_tv[i] = coord(ray_o[i]) - coord(in_v[i]);
            n1_d[i]  = coord(ray_d[i]);
        end
    end

    // normal = e0 x e2, p = d x e2, q = tv x e0
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_pa[0][i] = r1_e0[XA[i]] * r1_e2[XB[i]];
            n2_pb[0][i] = r1_e0[XB[i]] * r1_e2[XA[i]];
            n2_pa[1][i] = r1_d[XA[i]]  * r1_e2[XB[i]];
            n2_pb[1][i] = r1_d[XB[i]]  * r1_e2[XA[i]];
            n2_pa[2][i] = r1_tv[XA[i]] * r1_e0[XB[i]];
            n2_pb[2][i] = r1_tv[XB[i]] * r1_e0[XA[i]];
        end
    end

    // det = e0.p, nu = tv.p, nv = d.q, nt = e2.q
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            da[0][i] = r3_e0[i]; db[0][i] = r3_x[1][i];
            da[1][i] = r3_tv[i]; db[1][i] = r3_x[1][i];
            da[2][i] = r3_d[i];  db[2][i] = r3_x[2][i];
            da[3][i] = r3_e2[i]; db[3][i] = r3_x[2][i];
        end
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 3; i++) begin
                n4_lo[j][i] = da[j][i] * signed'({1'b0, db[j][i][LOW-1:0]});
                n4_hi[j][i] = da[j][i] * signed'(db[j][i][CRW-1:LOW]);
                n5_t[j][i]  = (DOTW'(r4_hi[j][i]) <<< LOW) + DOTW'(r4_lo[j][i]);
            end
            n6_s[j] = r5_t[j][0] + r5_t[j][1] + r5_t[j][2];
        end
    end

    always_comb begin
        det = r6_s[0];
        nu  = r6_s[1];
        nv  = r6_s[2];
        nt  = r6_s[3];
        nums[0] = nu;
        nums[1] = nv;
        nums[2] = nt;
        for (int l = 0; l < 3; l++) begin
            mag = nums[l][DOTW-1] ? DOTW'(-nums[l]) : DOTW'(nums[l]);
            n7_num[l] = {mag, {FRAC{1'b0}}};
            n7_side.neg[l] = nums[l][DOTW-1];
            nsat[l] = sat32(SATW'(r6_n[l] >>> FRAC));
        end
        n7_side.group_last = r_last[NS-2];
        n7_side.cull_ok = det > DET_EPS;
        n7_side.bary_ok = !nu[DOTW-1] && (nu <= det) && !nv[DOTW-1]
                          && ((SUMW'(nu) + SUMW'(nv)) <= SUMW'(det));
        n7_side.nrm_x = nsat[0];
        n7_side.nrm_y = nsat[1];
        n7_side.nrm_z = nsat[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_last[0] <= i_tri.group_last;
            for (int s = 1; s < NS - 1; s++) begin
                r_last[s] <= r_last[s-1];
            end
            r1_e0 <= n1_e0; r1_e2 <= n1_e2; r1_tv <= n1_tv; r1_d <= n1_d;
            r2_pa <= n2_pa; r2_pb <= n2_pb;
            r2_e0 <= r1_e0; r2_e2 <= r1_e2; r2_tv <= r1_tv; r2_d <= r1_d;
            for (int c = 0; c < 3; c++) begin
                for (int i = 0; i < 3; i++) begin
                    r3_x[c][i] <= CRW'(r2_pa[c][i]) - CRW'(r2_pb[c][i]);
                end
            end
            r3_e0 <= r2_e0; r3_e2 <= r2_e2; r3_tv <= r2_tv; r3_d <= r2_d;
            r4_lo <= n4_lo; r4_hi <= n4_hi; r4_n <= r3_x[0];
            r5_t <= n5_t; r5_n <= r4_n;
            r6_s <= n6_s; r6_n <= r5_n;
            r7_side <= n7_side;
            r7_den <= det;
            r7_num <= n7_num;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_side  = r7_side;
    assign o_den   = r7_den;
    assign o_num   = r7_num;

endmodule

// File: src/rti_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage, three lanes on one divisor
module rti_div import rti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  t_div_side         i_side,
    input  logic [DOTW-1:0]   i_den,
    input  logic [NUMW-1:0]   i_num [3],
    output logic              o_valid,
    output t_div_side         o_side,
    output logic [QW-1:0]     o_quo [3]
);

    logic [QW-1:0]   r_vld;
    t_div_side       r_side [QW];
    logic [DOTW-1:0] r_den [QW];
    logic [DOTW-1:0] r_rem [QW][3];
    logic [QW-1:0]   r_qn [QW][3];   // remaining dividend bits shift out, quotient in

    logic [DOTW-1:0] n_rem [QW][3];
    logic [QW-1:0]   n_qn [QW][3];
    logic [DOTW-1:0] den_in;
    logic [DOTW-1:0] rem_in;
    logic [QW-1:0]   qn_in;
    logic [RW-1:0]   trial;
    logic            ge;

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            den_in = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            for (int l = 0; l < 3; l++) begin
                if (k == 0) begin
                    rem_in = DOTW'(i_num[l][NUMW-1:QW]);
                    qn_in  = i_num[l][QW-1:0];
                end else begin
                    rem_in = r_rem[k-1][l];
                    qn_in  = r_qn[k-1][l];
                end
                trial = {rem_in, qn_in[QW-1]};
                ge = trial >= {1'b0, den_in};
                n_rem[k][l] = ge ? DOTW'(trial - {1'b0, den_in}) : trial[DOTW-1:0];
                n_qn[k][l]  = {qn_in[QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
                r_den[k]  <= r_den[k-1];
            end
            r_rem <= n_rem;
            r_qn  <= n_qn;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_quo   = r_qn[QW-1];

endmodule

// File: src/rti_fin.sv
`timescale 1ns / 1ps

module rti_fin import rti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  t_div_side          i_side,
    input  logic [QW-1:0]      i_quo [3],
    input  logic signed [31:0] i_win_min,
    input  logic signed [31:0] i_win_max,
    output logic               o_valid,
    output t_hit_out           o_res
);

    logic [1:0]             r_vld;
    t_div_side              r1_side;
    logic signed [QSW-1:0]  r1_q [3];   // u, v, t
    t_hit_out               r2_res;

    logic signed [QSW-1:0]  n1_q [3];
    logic signed [QSW-1:0]  qs;
    logic signed [SATW-1:0] w_full;
    logic                   in_win;
    logic                   hit;
    t_hit_out               n2_res;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            qs = signed'({1'b0, i_quo[l]});
            n1_q[l] = i_side.neg[l] ? -qs : qs;
        end
    end

    always_comb begin
        w_full = SATW'(ONE_Q16) - SATW'(r1_q[0]) - SATW'(r1_q[1]);
        in_win = (SATW'(r1_q[2]) >= SATW'(i_win_min)) && (SATW'(r1_q[2]) <= SATW'(i_win_max));
        hit = r1_side.cull_ok && r1_side.bary_ok && in_win;
        n2_res.hit = hit;
        n2_res.hit_distance = hit ? sat32(SATW'(r1_q[2])) : T_MISS;
        n2_res.bary_u = r1_side.cull_ok ? sat32(SATW'(r1_q[0])) : '0;
        n2_res.bary_v = r1_side.cull_ok ? sat32(SATW'(r1_q[1])) : '0;
        n2_res.bary_w = r1_side.cull_ok ? sat32(w_full) : ONE_Q16;
        n2_res.normal_x = r1_side.nrm_x;
        n2_res.normal_y = r1_side.nrm_y;
        n2_res.normal_z = r1_side.nrm_z;
        n2_res.group_last_out = r1_side.group_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_side <= i_side;
            r1_q    <= n1_q;
            r2_res  <= n2_res;
        end
    end

    assign o_valid = r_vld[1];
    assign o_res   = r2_res;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import rti_pkg::*;

    localparam int RES_LATENCY = 110;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_TRIS = 1880;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_tri_in  tri_val;
        bit       known;
        t_hit_out res;
    } t_tri_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_tri_valid = 1'b0;
    logic        o_tri_ready;
    t_tri_in     i_tri = '0;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    t_hit_out    o_res;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = REG_ORG_X;
    logic [31:0] i_cfg_data = '0;

    ray_triangle_intersect dut (.*);

    always #5 i_clk = ~i_clk;

    // ray registers as the block should hold them
    logic [31:0] ray_reg [8];
    t_hit_out    hit_q [$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          hits_seen = 0;
    int          culls_seen = 0;
    int          cycles = 0;

    function automatic t_wide to_coord(input logic [31:0] x);
        t_wide s;
        s = {x[CW-1:0], {(128-CW){1'b0}}};
        return s >>> (128 - CW);
    endfunction

    function automatic logic [31:0] clamp32(input t_wide x);
        if (x < -t_wide'(64'sh8000_0000)) return 32'h8000_0000;
        if (x > t_wide'(64'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
        return x[31:0];
    endfunction

    // moller-trumbore with culling, exact on a 128-bit datapath
    function automatic t_hit_out intersect_tri(input t_tri_in t);
        t_wide v0 [3], e0 [3], e2 [3], tv [3], d [3];
        t_wide nrm [3], p [3], q [3];
        t_wide det, nu, nv, nt, uq, vq, tq;
        logic [31:0] vin [9];
        t_hit_out r;
        vin = '{t.vert0_x, t.vert0_y, t.vert0_z, t.vert1_x, t.vert1_y, t.vert1_z,
                t.vert2_x, t.vert2_y, t.vert2_z};
        for (int i = 0; i < 3; i++) begin
            v0[i] = to_coord(vin[i]);
            e0[i] = to_coord(vin[3+i]) - v0[i];
            e2[i] = to_coord(vin[6+i]) - v0[i];
            tv[i] = to_coord(ray_reg[i]) - v0[i];
            d[i]  = to_coord(ray_reg[3+i]);
        end
        for (int i = 0; i < 3; i++) begin
            int a, b;
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            nrm[i] = e0[a] * e2[b] - e0[b] * e2[a];
            p[i]   = d[a] * e2[b] - d[b] * e2[a];
            q[i]   = tv[a] * e0[b] - tv[b] * e0[a];
        end
        det = e0[0] * p[0] + e0[1] * p[1] + e0[2] * p[2];
        nu  = tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2];
        nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        uq = 0;
        vq = 0;
        r.hit = 1'b0;
        r.hit_distance = T_MISS;
        if (det > 128'sd281474976) begin
            uq = (nu <<< 16) / det;
            vq = (nv <<< 16) / det;
            tq = (nt <<< 16) / det;
            r.hit = nu >= 0 && nu <= det && nv >= 0 && nu + nv <= det
                && tq >= t_wide'(signed'(ray_reg[REG_WIN_MIN]))
                && tq <= t_wide'(signed'(ray_reg[REG_WIN_MAX]));
            if (r.hit) r.hit_distance = clamp32(tq);
        end
        r.bary_u = clamp32(uq);
        r.bary_v = clamp32(vq);
        r.bary_w = clamp32(t_wide'(ONE_Q16) - uq - vq);
        r.normal_x = clamp32(nrm[0] >>> 16);
        r.normal_y = clamp32(nrm[1] >>> 16);
        r.normal_z = clamp32(nrm[2] >>> 16);
        r.group_last_out = t.group_last;
        return r;
    endfunction

    function automatic t_tri_in make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                         input bit last);
        return '{ax, ay, az, bx, by, bz, cx, cy, cz, last};
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", hit_q.size());
            $display("ray_triangle_intersect verification failed");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= $urandom_range(99) >= stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (hit_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_res);
            end else begin
                t_hit_out want;
                want = hit_q.pop_front();
                results_seen++;
                if (want.hit) hits_seen++;
                if (want.bary_u == 0 && want.bary_v == 0 && want.bary_w == ONE_Q16)
                    culls_seen++;
                if (o_res.hit !== want.hit || o_res.hit_distance !== want.hit_distance
                    || o_res.bary_u !== want.bary_u || o_res.bary_v !== want.bary_v
                    || o_res.bary_w !== want.bary_w || o_res.normal_x !== want.normal_x
                    || o_res.normal_y !== want.normal_y || o_res.normal_z !== want.normal_z
                    || o_res.group_last_out !== want.group_last_out) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d mismatch", results_seen);
                        $display("  expected %p", want);
                        $display("  actual   %p", o_res);
                    end
                end
            end
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_tri(input t_tri_in t, input bit known, input t_hit_out res);
        if ($urandom_range(99) < send_idle_pct) begin
            i_tri_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_tri <= t;
        i_tri_valid <= 1'b1;
        do @(posedge i_clk); while (!o_tri_ready);
        hit_q.insert(hit_q.size(), known ? res : intersect_tri(t));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_tri_valid <= 1'b0;
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (RES_LATENCY) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        ray_reg[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic write_ray(input int ox, oy, oz, dx, dy, dz, wmin, wmax);
        write_reg(REG_ORG_X, ox);
        write_reg(REG_ORG_Y, oy);
        write_reg(REG_ORG_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_WIN_MIN, wmin);
        write_reg(REG_WIN_MAX, wmax);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int small_val(input int span);
        return $urandom_range(2 * span) - span;
    endfunction

    initial begin
        t_tri_row rows [$];
        t_hit_out cull;
        int ox, oy, oz, dx, dy, dz;
        int mode;
        for (int i = 0; i < 7; i++) ray_reg[i] = '0;
        ray_reg[REG_WIN_MAX] = 32'h7FFF_FFFF;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // with the ray at reset the direction is zero, so every triangle culls
        cull = '{1'b0, T_MISS, 0, 0, ONE_Q16, 0, 0, 0, 1'b0};
        rows.insert(rows.size(), '{make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, cull});
        cull.normal_z = 32'sh0001_0000;
        cull.group_last_out = 1'b1;
        rows.insert(rows.size(), '{make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 1), 1, cull});
        // cross products past the 32-bit range saturate both ways
        cull.normal_z = 32'sh7FFF_FFFF;
        cull.group_last_out = 1'b0;
        rows.insert(rows.size(),
                    '{make_tri(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0),
                      1, cull});
        cull.normal_z = 32'sh8000_0000;
        rows.insert(rows.size(),
                    '{make_tri(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000, 0, 0),
                      1, cull});
        // rest is predicted: front and back faces, edges, corners, tiny det
        rows.insert(rows.size(), '{make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0, 1), 0, cull});
        rows.insert(rows.size(),
                    '{make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 65536, 0), 0, cull});
        rows.insert(rows.size(),
                    '{make_tri(16384, 16384, 0, 16384, 65536, 0, 65536, 16384, 0, 0),
                      0, cull});
        rows.insert(rows.size(),
                    '{make_tri(-65536, 0, 0, 0, 65536, 0, 65536, -65536, 0, 1), 0, cull});
        rows.insert(rows.size(), '{make_tri(0, 0, 0, 0, 8192, 0, 8192, 0, 0, 0), 0, cull});
        rows.insert(rows.size(), '{make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 0), 0, cull});
        rows.insert(rows.size(),
                    '{make_tri(0, 0, 1310720, 0, 65536, 1310720, 65536, 0, 1310720, 1),
                      0, cull});
        rows.insert(rows.size(),
                    '{make_tri(0, 0, -1310720, 0, 65536, -1310720, 65536, 0, -1310720, 0),
                      0, cull});
        rows.insert(rows.size(),
                    '{make_tri(32'h8000_0000, 32'h8000_0000, 0, 32'h8000_0000,
                               32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1),
                      0, cull});
        rows.insert(rows.size(),
                    '{make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, -1, -1, -1, 0), 0, cull});
        rows.insert(rows.size(), '{make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1), 0, cull});

        foreach (rows[i]) send_tri(rows[i].tri_val, rows[i].known, rows[i].res);
        drain_results();
        // ray pointing up the z axis through a quarter point of the unit square
        write_ray(16384, 16384, -65536, 0, 0, 65536, 0, 32'h7FFF_FFFF);
        foreach (rows[i]) send_tri(rows[i].tri_val, 0, rows[i].res);
        drain_results();
        // window that rejects everything but a narrow band
        write_ray(16384, 16384, -65536, 0, 0, 65536, 65536, 65536);
        foreach (rows[i]) send_tri(rows[i].tri_val, 0, rows[i].res);
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            mode = ph % 4;
            send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 52 : 13) : 0;
            stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 52 : 13) : 0;
            ox = small_val(1 << 18);
            oy = small_val(1 << 18);
            oz = small_val(1 << 18);
            dx = small_val(1 << 17);
            dy = small_val(1 << 17);
            dz = small_val(1 << 17);
            case (ph)
                1: write_ray(ox, oy, oz, dx, dy, dz, 32'h8000_0000, 32'h7FFF_FFFF);
                3: write_ray(ox, oy, oz, 0, 0, 0, 0, 32'h7FFF_FFFF);
                5: write_ray(ox, oy, oz, dx, dy, dz, 32'h0004_0000, 32'h0001_0000);
                6: write_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF);
                default: write_ray(ox, oy, oz, dx, dy, dz, small_val(1 << 17),
                                   $urandom_range(32'h7FFF_FFFF, 1 << 17));
            endcase
            // long hold-off so the pipe fills and back-pressures requests
            if (ph == 4) hold_cycles = 400;
            for (int n = 0; n < RANDOM_TRIS / 8; n++) begin
                t_tri_in t;
                int m;
                if ($urandom_range(99) < 15) begin
                    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, 1'($urandom)};
                end else begin
                    // triangle spread around a point the ray passes
                    m = $urandom_range(4, 1);
                    t.vert0_x = ox + dx * m + small_val(1 << 17);
                    t.vert0_y = oy + dy * m + small_val(1 << 17);
                    t.vert0_z = oz + dz * m + small_val(1 << 17);
                    t.vert1_x = ox + dx * m + small_val(1 << 17);
                    t.vert1_y = oy + dy * m + small_val(1 << 17);
                    t.vert1_z = oz + dz * m + small_val(1 << 17);
                    t.vert2_x = ox + dx * m + small_val(1 << 17);
                    t.vert2_y = oy + dy * m + small_val(1 << 17);
                    t.vert2_z = oz + dz * m + small_val(1 << 17);
                    t.group_last = 1'($urandom);
                end
                send_tri(t, 0, cull);
            end
            drain_results();
        end

        $display("checked %0d triangle results: %0d hits, %0d culled", results_seen,
                 hits_seen, culls_seen);
        $display("covered reset ray, axis ray, narrow and empty windows, zero and extreme rays");
        if (mismatches == 0 && hit_q.size() == 0) begin
            $display("ray_triangle_intersect verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("ray_triangle_intersect verification failed");
        end
        $finish;
    end

endmodule
